// ===== design/bfa_pkg.sv =====
// Shared types and status codes for the best-fit allocator.
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int FIELD_W  = 16;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd3;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  // Control from the sequencer to the best-fit tracker
  typedef struct packed {
    logic clear;
    logic valid;
  } bfa_scan_ctl_t;

endpackage

// ===== design/bfa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/bfa_scan.sv =====
// Best-fit tracker: compares one table entry per cycle against the request.
`timescale 1ns / 1ps

module bfa_scan #(
  parameter int AW = 16,
  parameter int IW = 4
) (
  input  logic                   clk,
  input  bfa_pkg::bfa_scan_ctl_t ctl,
  input  logic [IW-1:0]          idx,
  input  logic [AW-1:0]          blk_start,
  input  logic [15:0]            blk_size,
  input  logic [15:0]            req,
  output logic                   found,
  output logic [IW-1:0]          best_idx,
  output logic [15:0]            best_left,
  output logic [AW-1:0]          best_start
);

  import bfa_pkg::*;

  logic              found_r, found_nxt;
  logic [IW-1:0]     best_idx_r, best_idx_nxt;
  logic [FIELD_W-1:0] best_left_r, best_left_nxt;
  logic [AW-1:0]     best_start_r, best_start_nxt;
  logic [FIELD_W-1:0] left;

  assign left = blk_size - req;

  always_comb begin
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_left_nxt  = best_left_r;
    best_start_nxt = best_start_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (ctl.valid && blk_size >= req) begin
      // strict compare keeps the earliest entry on a tie
      if (!found_r || left < best_left_r) begin
        found_nxt      = 1'b1;
        best_idx_nxt   = idx;
        best_left_nxt  = left;
        best_start_nxt = blk_start;
      end
    end
  end

  always_ff @(posedge clk) begin
    found_r      <= found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_left_r  <= best_left_nxt;
    best_start_r <= best_start_nxt;
  end

  assign found      = found_r;
  assign best_idx   = best_idx_r;
  assign best_left  = best_left_r;
  assign best_start = best_start_r;

endmodule

// ===== design/best_fit_allocator.sv =====
// Top level of the best-fit allocator: sequencer, free-block table and result register.
//
//   channel  dir  ports           beat contents
//   in_      in   tvalid/tready   tuser: mode; tdata: block_start, block_size, request_size
//   out_     out  tvalid/tready   tuser: status; tdata: alloc_address
//
// An add passes through S_ADD and S_RESP before out_tvalid rises. An allocate reads one
// entry a cycle through the single table read port, then decides in S_DECIDE; when a
// used-up block is removed, later entries move down one a cycle in S_SHIFT. One item is
// in work at a time; the next beat is taken the cycle after the result is loaded, and a
// result held by out_tready stalls the following one in S_RESP. Reset clears the count,
// sequencer, read-pending flag and output valid only.
`timescale 1ns / 1ps

module best_fit_allocator #(
  parameter int MAX_BLOCKS = 16,
  parameter int ADDR_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // block_start[15:0], block_size[31:16], request_size[47:32]
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // alloc_address
  output logic [1:0]  out_tuser   // status
);

  import bfa_pkg::*;

  localparam int AW = ADDR_BITS;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int MW = AW + FIELD_W;
  localparam int SW = (AW > FIELD_W) ? AW : FIELD_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_BLOCKS);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ADD    = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DECIDE = 6'b001000,
    S_SHIFT  = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [IW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0]       bstart_r, bstart_nxt;
  logic [FIELD_W-1:0]  bsize_r, bsize_nxt;
  logic [FIELD_W-1:0]  req_r, req_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [FIELD_W-1:0]  res_addr_r, res_addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [FIELD_W-1:0]  out_addr_r, out_addr_nxt;

  logic                mem_we, mem_re;
  logic [IW-1:0]       mem_waddr, mem_raddr;
  logic [MW-1:0]       mem_wdata, mem_rdata;

  bfa_scan_ctl_t       scan_ctl;
  logic                best_found;
  logic [IW-1:0]       best_idx;
  logic [FIELD_W-1:0]  best_left;
  logic [AW-1:0]       best_start;
  logic [SW-1:0]       start_sum;
  logic [SW-1:0]       in_start_ext;
  logic [SW-1:0]       best_start_ext;

  assign in_start_ext   = SW'(in_tdata[15:0]);
  assign best_start_ext = SW'(best_start);
  assign start_sum      = best_start_ext + SW'(req_r);

  bfa_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bfa_scan #(
    .AW (AW),
    .IW (IW)
  ) u_scan (
    .clk        (clk),
    .ctl        (scan_ctl),
    .idx        (cmp_idx_r),
    .blk_start  (mem_rdata[MW-1:FIELD_W]),
    .blk_size   (mem_rdata[FIELD_W-1:0]),
    .req        (req_r),
    .found      (best_found),
    .best_idx   (best_idx),
    .best_left  (best_left),
    .best_start (best_start)
  );

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    rd_pend_nxt    = rd_pend_r;
    cmp_idx_nxt    = cmp_idx_r;
    bstart_nxt     = bstart_r;
    bsize_nxt      = bsize_r;
    req_nxt        = req_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r[IW-1:0];
    mem_wdata      = {bstart_r, bsize_r};
    mem_re         = 1'b0;
    mem_raddr      = rd_idx_r[IW-1:0];
    scan_ctl       = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          bstart_nxt  = in_start_ext[AW-1:0];
          bsize_nxt   = in_tdata[31:16];
          req_nxt     = in_tdata[47:32];
          rd_idx_nxt  = '0;
          rd_pend_nxt = 1'b0;
          if (in_tuser == MODE_ALLOC) begin
            scan_ctl.clear = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            state_nxt = S_ADD;
          end
        end
      end
      S_ADD: begin
        res_addr_nxt = '0;
        if (count_r == FULL_CNT) begin
          res_status_nxt = ST_FULL;
        end else begin
          mem_we         = 1'b1;
          count_nxt      = count_r + CW'(1);
          res_status_nxt = ST_ADDED;
        end
        state_nxt = S_RESP;
      end
      S_SCAN: begin
        // issue one read a cycle; the tracker sees each entry in the cycle after its read
        scan_ctl.valid = rd_pend_r;
        if (rd_idx_r < count_r) begin
          mem_re      = 1'b1;
          cmp_idx_nxt = rd_idx_r[IW-1:0];
          rd_idx_nxt  = rd_idx_r + CW'(1);
          rd_pend_nxt = 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
          if (!rd_pend_r) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (!best_found) begin
          res_status_nxt = ST_NOFIT;
          res_addr_nxt   = '0;
          state_nxt      = S_RESP;
        end else begin
          res_status_nxt = ST_ALLOC;
          res_addr_nxt   = best_start_ext[FIELD_W-1:0];
          if (best_left != '0) begin
            mem_we    = 1'b1;
            mem_waddr = best_idx;
            mem_wdata = {start_sum[AW-1:0], best_left};
            state_nxt = S_RESP;
          end else begin
            rd_idx_nxt  = CW'(best_idx) + CW'(1);
            rd_pend_nxt = 1'b0;
            state_nxt   = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // read entry i+1, write it back one place lower on the next cycle
        if (rd_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_idx_r - IW'(1);
          mem_wdata = mem_rdata;
        end
        if (rd_idx_r < count_r) begin
          mem_re      = 1'b1;
          cmp_idx_nxt = rd_idx_r[IW-1:0];
          rd_idx_nxt  = rd_idx_r + CW'(1);
          rd_pend_nxt = 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
          if (!rd_pend_r) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        // hold until the result register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    bstart_r     <= bstart_nxt;
    bsize_r      <= bsize_nxt;
    req_r        <= req_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_addr_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("free count beyond table depth");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (count_r != '0))
    else $error("gap closing on an empty table");

  a_shift_wr_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && mem_we) |-> (cmp_idx_r != '0))
    else $error("shift write below entry zero");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_ALLOC) |-> (out_addr_r == '0))
    else $error("address set on a non-allocate result");

  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD && count_r != FULL_CNT) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("add did not advance the count");
`endif

endmodule

// ===== sim/best_fit_allocator_test.sv =====
// Self-checking testbench for the best-fit allocator: directed script, then random traffic.
`timescale 1ns / 1ps

module best_fit_allocator_test;
  import bfa_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 1750;
  localparam int SEGMENTS = 5;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  addr;
  } grant_t;

  typedef struct {
    logic                mode;
    logic [FIELD_W-1:0]  bstart;
    logic [FIELD_W-1:0]  bsize;
    logic [FIELD_W-1:0]  req;
    int                  reps;
    bit                  typed;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  addr;
  } script_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // block_start, block_size, request_size
  logic        in_tuser = 1'b0; // mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // alloc_address
  logic [1:0]  out_tuser;       // status

  // Shadow of the free-block table
  logic [FIELD_W-1:0] shadow_start [TABLE_DEPTH];
  logic [FIELD_W-1:0] shadow_size  [TABLE_DEPTH];
  int                 shadow_count;

  grant_t pending_grants [$];
  int     mismatches;
  int     beats_sent;
  int     status_seen [4];
  int     idle_pct;
  int     stall_pct;
  longint cycles;

  // Directed script: the fill row repeats, stepping the start by 0x100
  script_row_t script [8] = '{
    '{MODE_ALLOC, 16'h0000, 16'h0000, 16'h0000, 1,  1'b1, ST_NOFIT, 16'h0000},
    '{MODE_ADD,   16'h0000, 16'h0000, 16'h0000, 1,  1'b1, ST_ADDED, 16'h0000},
    '{MODE_ADD,   16'hFFFF, 16'hFFFF, 16'h0000, 1,  1'b1, ST_ADDED, 16'h0000},
    '{MODE_ADD,   16'hFFF0, 16'h0040, 16'h0000, 1,  1'b1, ST_ADDED, 16'h0000},
    '{MODE_ADD,   16'h1000, 16'h0010, 16'h0000, 1,  1'b1, ST_ADDED, 16'h0000},
    '{MODE_ADD,   16'h8000, 16'h0100, 16'h0000, 12, 1'b1, ST_ADDED, 16'h0000},
    '{MODE_ADD,   16'h7000, 16'h0001, 16'h0000, 1,  1'b1, ST_FULL,  16'h0000},
    '{MODE_ALLOC, 16'h0000, 16'h0000, 16'h0000, 1,  1'b0, ST_ALLOC, 16'h0000}
  };
  // Allocations walked after the fill: zero-size block, whole-space block, no fit,
  // wrap of the moved start, tie to the earliest, zero request, exact fit mid-table
  logic [FIELD_W-1:0] script_reqs [7] = '{16'h0000, 16'hFFFF, 16'h0101, 16'h0030,
                                          16'h0010, 16'h0000, 16'h0100};

  best_fit_allocator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_grants.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    $display("MISMATCH at %0t: %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  // Best fit: smallest leftover wins, earliest entry on a tie; a used-up block is dropped
  function automatic grant_t predict_grant(input logic mode, input logic [15:0] bstart,
                                           input logic [15:0] bsize,
                                           input logic [15:0] req);
    grant_t g;
    int best;
    logic [FIELD_W-1:0] best_left;
    g.addr = '0;
    best = -1;
    best_left = '0;
    if (mode == MODE_ADD) begin
      if (shadow_count >= TABLE_DEPTH) begin
        g.status = ST_FULL;
      end else begin
        shadow_start[shadow_count] = bstart;
        shadow_size[shadow_count] = bsize;
        shadow_count++;
        g.status = ST_ADDED;
      end
    end else begin
      for (int i = 0; i < shadow_count; i++) begin
        if (shadow_size[i] >= req && (best < 0 || shadow_size[i] - req < best_left)) begin
          best = i;
          best_left = shadow_size[i] - req;
        end
      end
      if (best < 0) begin
        g.status = ST_NOFIT;
      end else begin
        g.status = ST_ALLOC;
        g.addr = shadow_start[best];
        shadow_start[best] = shadow_start[best] + req;
        shadow_size[best] = best_left;
        if (best_left == '0) begin
          for (int i = best; i + 1 < shadow_count; i++) begin
            shadow_start[i] = shadow_start[i + 1];
            shadow_size[i] = shadow_size[i + 1];
          end
          shadow_count--;
        end
      end
    end
    return g;
  endfunction

  // Drive one beat from the falling edge, hold until taken, then log what it should give
  task automatic send_beat(input logic mode, input logic [15:0] bstart,
                           input logic [15:0] bsize, input logic [15:0] req,
                           input bit typed, input grant_t typed_grant);
    grant_t g;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = mode;
    in_tdata = {req, bsize, bstart};
    do @(posedge clk); while (!in_tready);
    g = predict_grant(mode, bstart, bsize, req);
    pending_grants.push_back(typed ? typed_grant : g);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int n);
    logic               mode;
    logic [FIELD_W-1:0] bstart;
    logic [FIELD_W-1:0] bsize;
    logic [FIELD_W-1:0] req;
    int                 add_pct;
    int                 pick;
    int                 slot;
    grant_t             unused;
    unused = '{ST_ADDED, '0};
    // Swing between filling and draining so the table runs from empty to full
    if (shadow_count == 0) add_pct = 90;
    else if (shadow_count >= TABLE_DEPTH) add_pct = 12;
    else add_pct = ((n / 60) % 2 == 0) ? 70 : 30;
    mode = ($urandom_range(99) < add_pct) ? MODE_ADD : MODE_ALLOC;
    bstart = 16'($urandom_range(16'hFFFF));
    bsize = 16'($urandom_range(16'hFFFF));
    req = 16'($urandom_range(16'hFFFF));
    if (mode == MODE_ADD) begin
      pick = $urandom_range(99);
      if (pick < 10) bsize = 16'h0000;
      else if (pick < 20) bsize = 16'hFFFF;
      else if (pick < 60) bsize = 16'($urandom_range(64, 1));
    end else if (shadow_count > 0) begin
      pick = $urandom_range(99);
      slot = $urandom_range(shadow_count - 1);
      if (pick < 35) req = shadow_size[slot];
      else if (pick < 50) req = shadow_size[slot] - 16'd1;
      else if (pick < 60) req = shadow_size[slot] + 16'd1;
      else if (pick < 68) req = 16'h0000;
      else if (pick < 85) req = 16'($urandom_range(64, 1));
    end
    send_beat(mode, bstart, bsize, req, 1'b0, unused);
  endtask

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_tvalid && out_tready) begin
      status_seen[out_tuser]++;
      if (pending_grants.size() == 0) begin
        flag_mismatch("result with nothing pending, status", 0, 32'(out_tuser));
      end else begin
        want = pending_grants.pop_front();
        if (out_tuser !== want.status)
          flag_mismatch("status", 32'(want.status), 32'(out_tuser));
        if (out_tdata !== want.addr)
          flag_mismatch("alloc_address", 32'(want.addr), 32'(out_tdata));
      end
    end
  end

  initial begin
    grant_t typed_grant;
    int     seg_idle [SEGMENTS];
    int     seg_stall [SEGMENTS];
    seg_idle = '{0, 81, 0, 18, 0};
    seg_stall = '{0, 0, 81, 18, 0};
    cycles = 0;
    mismatches = 0;
    beats_sent = 0;
    shadow_count = 0;
    status_seen = '{0, 0, 0, 0};
    idle_pct = 0;
    stall_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (script[r]) begin
      typed_grant = '{script[r].status, script[r].addr};
      if (script[r].typed) begin
        for (int k = 0; k < script[r].reps; k++) begin
          send_beat(script[r].mode, script[r].bstart + 16'(k * 16'h0100), script[r].bsize,
                    script[r].req, 1'b1, typed_grant);
        end
      end else begin
        foreach (script_reqs[q]) begin
          send_beat(MODE_ALLOC, 16'h0000, 16'h0000, script_reqs[q], 1'b0, typed_grant);
        end
      end
    end

    for (int s = 0; s < SEGMENTS; s++) begin
      idle_pct = seg_idle[s];
      stall_pct = seg_stall[s];
      for (int n = 0; n < RANDOM_ITEMS / SEGMENTS; n++) send_random(n);
    end
    in_tvalid = 1'b0;
    stall_pct = 0;

    while (pending_grants.size() != 0) @(posedge clk);
    // Allow for a late stray beat
    repeat (60) @(posedge clk);

    $display("%0d beats sent over %0d cycles with idle and stall mixes", beats_sent, cycles);
    $display("results: %0d added, %0d table full, %0d allocated, %0d no fit",
             status_seen[ST_ADDED], status_seen[ST_FULL], status_seen[ST_ALLOC],
             status_seen[ST_NOFIT]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bfa_pkg.sv
design/bfa_ram.sv
design/bfa_scan.sv
design/best_fit_allocator.sv
sim/best_fit_allocator_test.sv
